/* rtl/core/oled_text_glyph_stream_defines.svh */
// Assertion macros shared by the glyph stream RTL.
`ifndef OLED_TEXT_GLYPH_STREAM_DEFINES_SVH
`define OLED_TEXT_GLYPH_STREAM_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define OTGS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define OTGS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define OTGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/otgs_pkg.sv */
// Shared types, codes, font table and glyph column helpers for the glyph stream.
package otgs_pkg;

    typedef logic [14:0] glyph_t;
    typedef logic [3:0]  bcd_digit_t;

    localparam int MAG_W      = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * 4;

    // Operation codes
    localparam logic [1:0] OP_CURSOR = 2'd0;
    localparam logic [1:0] OP_CHAR   = 2'd1;
    localparam logic [1:0] OP_NUMBER = 2'd2;

    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam glyph_t     GLYPH_DASH   = 15'h01C0;

    // Look up the 3x5 glyph; fold lower case, map unknown codes to a dash.
    function automatic glyph_t font_bits(input logic [7:0] ch_in);
        logic [7:0] ch;
        glyph_t     g;
        ch = ch_in;
        if (ch >= 8'h61 && ch <= 8'h7A) begin
            ch = ch - 8'd32;
        end
        case (ch)
            8'h30: g = 15'h7B6F;
            8'h31: g = 15'h2492;
            8'h32: g = 15'h73E7;
            8'h33: g = 15'h73CF;
            8'h34: g = 15'h5BC9;
            8'h35: g = 15'h79CF;
            8'h36: g = 15'h79EF;
            8'h37: g = 15'h7249;
            8'h38: g = 15'h7BEF;
            8'h39: g = 15'h7BCF;
            8'h41: g = 15'h2BEA;
            8'h42: g = 15'h7BEF;
            8'h43: g = 15'h7927;
            8'h44: g = 15'h6B6E;
            8'h45: g = 15'h79E7;
            8'h46: g = 15'h79E4;
            8'h47: g = 15'h79AF;
            8'h48: g = 15'h5BEA;
            8'h49: g = 15'h7497;
            8'h4A: g = 15'h124E;
            8'h4B: g = 15'h5ACA;
            8'h4C: g = 15'h4927;
            8'h4D: g = 15'h5F6B;
            8'h4E: g = 15'h5B6A;
            8'h4F: g = 15'h7B6F;
            8'h50: g = 15'h7BE4;
            8'h51: g = 15'h7B7B;
            8'h52: g = 15'h7BEA;
            8'h53: g = 15'h79CF;
            8'h54: g = 15'h7492;
            8'h55: g = 15'h5B6F;
            8'h56: g = 15'h5B54;
            8'h57: g = 15'h5B7F;
            8'h58: g = 15'h5AAB;
            8'h59: g = 15'h5A92;
            8'h5A: g = 15'h72A7;
            8'h2D: g = GLYPH_DASH;
            8'h3A: g = 15'h0820;
            8'h2E: g = 15'h0002;
            8'h2F: g = 15'h1248;
            8'h20: g = 15'h0000;
            default: g = GLYPH_DASH;
        endcase
        return g;
    endfunction

    // Column byte x of a glyph: bit y is row y; the fourth column is spacing.
    function automatic logic [7:0] glyph_column(input glyph_t g, input logic [1:0] x);
        logic [7:0] col;
        col = 8'h00;
        if (x != 2'd3) begin
            for (int y = 0; y < 5; y++) begin
                col[y] = g[(4 - y) * 3 + (2 - int'(x))];
            end
        end
        return col;
    endfunction

endpackage

/* rtl/core/oled_text_glyph_stream.sv */
// Top level: display request stream in, panel command/data word stream out.
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+----------------------------------
//  s_*      | in        | s_tvalid/s_tready  | one display request
//  m_*      | out       | m_tvalid/m_tready  | one panel write, tlast on final word
//  cfg_*    | in        | cfg_valid/cfg_ready| display_ready bit
//
// Sequencing: the sequencer takes one request at a time and drops s_tready until
// its last word is loaded into the output register. After the accept cycle, set
// cursor sends three command words and a character four words. A number first
// runs the converter (start, then one bit per cycle), skips leading zero digits
// and sends four words per glyph, up to 44 words. Cursor and character requests
// while the panel is not ready, and undefined operations, produce nothing and
// finish in the accept cycle. Reset clears the sequencer, output valid and
// display_ready. A stall on m_tready holds the output word and the emit step.
module oled_text_glyph_stream
    import otgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // page_row[7:0], text_column[15:8], character[23:16],
                                   // number[55:24]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // payload[7:0]
    output logic        m_tuser,   // is_data[0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

`include "oled_text_glyph_stream_defines.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // Request fields
    logic [1:0]       in_op;
    logic [7:0]       in_page;
    logic [7:0]       in_tcol;
    logic [7:0]       in_char;
    logic [MAG_W-1:0] in_num;

    assign in_op   = s_tuser;
    assign in_page = s_tdata[7:0];
    assign in_tcol = s_tdata[15:8];
    assign in_char = s_tdata[23:16];
    assign in_num  = s_tdata[55:24];

    logic [1:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic [7:0] char_reg, char_next;
    logic [2:0] page_reg, page_next;
    logic [6:0] pix_reg, pix_next;
    logic [1:0] col_reg, col_next;      // glyph column, or command step for cursor
    logic [3:0] dig_reg, dig_next;
    logic       neg_reg, neg_next;      // minus glyph still to send
    logic       ready_reg, ready_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic       out_user_reg, out_user_next;
    logic       out_last_reg, out_last_next;

    logic             accept;
    logic             bcd_start;
    logic             bcd_done;
    logic [BCD_W-1:0] bcd;
    logic [MAG_W-1:0] in_mag;
    bcd_digit_t       cur_digit;
    logic [7:0]       glyph_code;
    logic [7:0]       emit_byte;
    logic             emit_data;
    logic             emit_last;
    logic             out_free;
    logic             emit_fire;
    logic [7:0]       pix_full;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign in_mag    = in_num[MAG_W-1] ? (~in_num + 32'd1) : in_num;
    assign bcd_start = accept && (in_op == OP_NUMBER);
    assign pix_full  = {in_tcol[5:0], 2'b00};

    otgs_bcd_unit u_bcd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start),
        .mag   (in_mag),
        .done  (bcd_done),
        .bcd   (bcd)
    );

    assign cur_digit = bcd[dig_reg*4 +: 4];
    assign out_free  = !out_valid_reg || m_tready;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;

    // Pick the glyph and column byte for the current step.
    always_comb
    begin
        glyph_code = char_reg;
        emit_byte  = 8'h00;
        emit_data  = 1'b1;
        emit_last  = 1'b0;
        if (op_reg == OP_CURSOR) begin
            emit_data = 1'b0;
            case (col_reg)
                2'd0:    emit_byte = CMD_PAGE + {5'd0, page_reg};
                2'd1:    emit_byte = {4'd0, pix_reg[3:0]};
                default: emit_byte = CMD_COL_HIGH + {5'd0, pix_reg[6:4]};
            endcase
            emit_last = (col_reg == 2'd2);
        end else begin
            if (op_reg == OP_NUMBER) begin
                glyph_code = neg_reg ? CH_DASH : (CH_ZERO + {4'd0, cur_digit});
                emit_last  = (col_reg == 2'd3) && !neg_reg && (dig_reg == 4'd0);
            end else begin
                emit_last  = (col_reg == 2'd3);
            end
            emit_byte = glyph_column(font_bits(glyph_code), col_reg);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        char_next  = char_reg;
        page_next  = page_reg;
        pix_next   = pix_reg;
        col_next   = col_reg;
        dig_next   = dig_reg;
        neg_next   = neg_reg;
        ready_next = ready_reg;
        if (cfg_valid && cfg_ready) begin
            ready_next = cfg_data;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    op_next   = in_op;
                    char_next = in_char;
                    page_next = (in_page > 8'd7) ? 3'd7 : in_page[2:0];
                    pix_next  = pix_full[7] ? 7'd127 : pix_full[6:0];
                    col_next  = 2'd0;
                    neg_next  = in_num[MAG_W-1];
                    if (in_op == OP_NUMBER) begin
                        state_next = ST_CONV;
                    end else if ((in_op == OP_CURSOR || in_op == OP_CHAR) && ready_reg) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_CONV:
            begin
                if (bcd_done) begin
                    dig_next   = 4'd9;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zero digits, keep at least one.
                if (dig_reg != 4'd0 && cur_digit == 4'd0) begin
                    dig_next = dig_reg - 4'd1;
                end else begin
                    col_next   = 2'd0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire) begin
                    col_next = col_reg + 2'd1;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end else if (op_reg == OP_NUMBER && col_reg == 2'd3) begin
                        if (neg_reg) begin
                            neg_next = 1'b0;
                        end else begin
                            dig_next = dig_reg - 4'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load a new word when empty or when the current one leaves.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (emit_fire) begin
            out_valid_next = 1'b1;
            out_data_next  = emit_byte;
            out_user_next  = emit_data;
            out_last_next  = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        char_reg     <= char_next;
        page_reg     <= page_next;
        pix_reg      <= pix_next;
        col_reg      <= col_next;
        dig_reg      <= dig_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    `OTGS_ASSERT_NEXT(a_last_ends_item, emit_fire && emit_last, state_reg == ST_IDLE, "sequencer did not return to idle after last word")
    `OTGS_ASSERT_IMPL(a_digit_index, state_reg == ST_SKIP || (state_reg == ST_EMIT && op_reg == OP_NUMBER), dig_reg <= 4'd9, "digit index out of range")
    `OTGS_ASSERT_IMPL(a_bcd_digit, state_reg == ST_SKIP, cur_digit <= 4'd9, "converter produced a non-decimal digit")
    `OTGS_ASSERT_IMPL(a_cursor_steps, state_reg == ST_EMIT && op_reg == OP_CURSOR, col_reg != 2'd3, "cursor sequence ran past three commands")
    `OTGS_ASSERT_IMPL(a_done_in_conv, bcd_done, state_reg == ST_CONV, "converter finished outside conversion state")

endmodule

/* rtl/core/otgs_bcd_unit.sv */
// Shift-and-add-3 binary to BCD converter, one magnitude bit per cycle.
module otgs_bcd_unit
    import otgs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MAG_W-1:0] mag,
    output logic             done,
    output logic [BCD_W-1:0] bcd
);

    logic [BCD_W-1:0] bcd_reg, bcd_next, bcd_adj;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    // Add 3 to every digit of 5 or more before the shift.
    always_comb
    begin
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (bcd_reg[d*4 +: 4] >= 4'd5) begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
            end
        end
    end

    always_comb
    begin
        bcd_next  = bcd_reg;
        mag_next  = mag_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            bcd_next  = '0;
            mag_next  = mag;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[MAG_W-1]};
            mag_next = {mag_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        mag_reg <= mag_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule
